FILE: sv/comment_stripping_line_splitter_defines.svh
// Assertion macros shared by the comment stripper modules.
`ifndef COMMENT_STRIPPING_LINE_SPLITTER_DEFINES_SVH
`define COMMENT_STRIPPING_LINE_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define CCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define CCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ccs_pkg.sv
// Types and character constants for the comment stripper.
package ccs_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_FF    = 8'hFF;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_t;

  // One queue entry per input byte that yields output.
  typedef struct packed {
    logic        has_slash;  // emit a held slash first
    logic        has_main;   // a main beat follows
    kind_t       kind;
    logic [7:0]  data;
    logic [31:0] count;      // line count before this byte
  } op_t;

  // One output beat.
  typedef struct packed {
    logic [31:0] count;
    logic [7:0]  data;
    kind_t       kind;
    logic        last;
  } beat_t;

endpackage

FILE: sv/ccs_front.sv
// Front end: scan state machine and line counter, pushes output work to the queue.
module ccs_front
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       full,
  output logic       push,
  output op_t        push_data
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_BSTAR  = 3'd3,
    MODE_LINE   = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] lines;
  logic        accept;
  logic        is_end;
  logic        ends;

  // outcome of a byte seen in normal mode
  mode_t       nm_mode;
  logic        nm_main;
  kind_t       nm_kind;
  logic        nm_ends;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign is_end   = (s_tdata == CH_NUL) || (s_tdata == CH_FF);

  always_comb begin
    nm_mode = MODE_NORMAL;
    nm_main = 1'b0;
    nm_kind = KIND_TEXT;
    nm_ends = 1'b0;
    if (is_end) begin
      nm_main = 1'b1;
      nm_kind = KIND_EOT;
      nm_ends = 1'b1;
    end else if (s_tdata == CH_CR) begin
      nm_main = 1'b0;
    end else if (s_tdata == CH_LF) begin
      nm_main = 1'b1;
      nm_kind = KIND_EOL;
      nm_ends = 1'b1;
    end else if (s_tdata == CH_SLASH) begin
      nm_mode = MODE_SLASH;
    end else begin
      nm_main = 1'b1;
    end
  end

  always_comb begin
    mode_next           = mode;
    ends                = 1'b0;
    push_data.has_slash = 1'b0;
    push_data.has_main  = 1'b0;
    push_data.kind      = KIND_TEXT;
    push_data.count     = lines;
    unique case (mode)
      MODE_SLASH: begin
        if (s_tdata == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else if (s_tdata == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else begin
          push_data.has_slash = 1'b1;
          push_data.has_main  = nm_main;
          push_data.kind      = nm_kind;
          mode_next           = nm_mode;
          ends                = nm_ends;
        end
      end
      MODE_BLOCK: begin
        if (is_end) begin
          push_data.has_main = 1'b1;
          push_data.kind     = KIND_EOT;
          ends               = 1'b1;
          mode_next          = MODE_NORMAL;
        end else if (s_tdata == CH_STAR) begin
          mode_next = MODE_BSTAR;
        end
      end
      MODE_BSTAR: begin
        if (is_end) begin
          push_data.has_main = 1'b1;
          push_data.kind     = KIND_EOT;
          ends               = 1'b1;
          mode_next          = MODE_NORMAL;
        end else if (s_tdata == CH_SLASH) begin
          mode_next = MODE_NORMAL;
        end else if (s_tdata != CH_STAR) begin
          mode_next = MODE_BLOCK;
        end
      end
      MODE_LINE: begin
        if (is_end) begin
          push_data.has_main = 1'b1;
          push_data.kind     = KIND_EOT;
          ends               = 1'b1;
          mode_next          = MODE_NORMAL;
        end else if (s_tdata == CH_LF) begin
          push_data.has_main = 1'b1;
          push_data.kind     = KIND_EOL;
          ends               = 1'b1;
          mode_next          = MODE_NORMAL;
        end
      end
      default: begin
        push_data.has_main = nm_main;
        push_data.kind     = nm_kind;
        mode_next          = nm_mode;
        ends               = nm_ends;
      end
    endcase
    // line marks carry no byte
    push_data.data = (push_data.kind == KIND_TEXT) ? s_tdata : CH_NUL;
  end

  assign push = accept && (push_data.has_slash || push_data.has_main);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      lines <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      lines <= lines + {31'd0, ends};
    end
  end

endmodule

FILE: sv/ccs_fifo.sv
// Short queue between the front end and the output stage.
`include "comment_stripping_line_splitter_defines.svh"

module ccs_fifo
  import ccs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_data,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  op_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == FULL_CNT);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CCS_ASSERT_NOW(a_no_overflow, full, !push, "queue written while full")
  `CCS_ASSERT_NOW(a_no_underflow, empty, !pop, "queue read while empty")
  `CCS_ASSERT_NEXT(a_count_track, push && !pop && !full, count == $past(count) + 1'b1,
                   "queue count lost a push")

endmodule

FILE: sv/ccs_back.sv
// Output stage: expands queue entries into one or two registered beats.
`include "comment_stripping_line_splitter_defines.svh"

module ccs_back
  import ccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  op_t         head,
  input  logic        empty,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  beat_t out_beat;
  beat_t pend;
  logic  pend_valid;
  logic  load;
  beat_t main_beat;
  beat_t slash_beat;

  assign load = !m_tvalid || m_tready;
  assign pop  = load && !pend_valid && !empty;

  always_comb begin
    main_beat.data  = head.data;
    main_beat.kind  = head.kind;
    main_beat.count = (head.kind == KIND_TEXT) ? head.count : head.count + 32'd1;
    main_beat.last  = 1'b1;
    slash_beat.data  = CH_SLASH;
    slash_beat.kind  = KIND_TEXT;
    slash_beat.count = head.count;
    slash_beat.last  = !head.has_main;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        m_tvalid   <= 1'b1;
        out_beat   <= pend;
        pend_valid <= 1'b0;
      end else if (!empty) begin
        m_tvalid <= 1'b1;
        if (head.has_slash) begin
          // hold the main beat behind the slash
          out_beat   <= slash_beat;
          pend       <= main_beat;
          pend_valid <= head.has_main;
        end else begin
          out_beat <= main_beat;
        end
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {out_beat.count, out_beat.data};
  assign m_tuser = out_beat.kind;
  assign m_tlast = out_beat.last;

  `CCS_ASSERT_NOW(a_pend_behind_slash, pend_valid,
                  m_tvalid && !m_tlast && (m_tdata[7:0] == CH_SLASH),
                  "pending beat without a slash beat in front")
  `CCS_ASSERT_NOW(a_mark_no_byte, m_tvalid && (m_tuser != KIND_TEXT),
                  (m_tdata[7:0] == CH_NUL) && m_tlast,
                  "line mark carries a byte or is not last")
  `CCS_ASSERT_NOW(a_no_pop_with_pend, pend_valid, !pop,
                  "queue popped while a beat is pending")

endmodule

FILE: sv/comment_stripping_line_splitter.sv
// Top level of the comment stripper: front end, queue and output stage.
//
// Input stream s_*: one text byte per beat in s_tdata. Bytes 0 and 255 end
// the text. Output stream m_*: m_tdata carries the kept byte and the running
// line count, m_tuser the beat kind (text, end of line, end of text), and
// m_tlast marks the last beat caused by one input byte.
// Carriage returns, block comments and line comments are removed; the
// newline of a line comment still ends the line.
// Throughput: one input byte per cycle while the queue is not full. An input
// that yields two beats (a held slash plus the byte after it) sends them one
// after the other; the queue absorbs these. A byte's beat is written to the
// queue at the accepting edge, then loaded into the output register when it
// is free; the beat behind a held slash follows from the pending register.
// When m_tready is low the output register holds, the queue fills, and
// s_tready drops once it is full. Bytes that yield nothing never enter the
// queue. Reset clears the scan state, the line count and the queue.
module comment_stripping_line_splitter
  import ccs_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] line_count
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  logic push, pop, empty, full;
  op_t  push_data, head;

  ccs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  ccs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  ccs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/sv/comment_stripping_line_splitter_tb.sv
// Self-checking testbench for the comment stripping line splitter.
module comment_stripping_line_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  typedef enum logic [2:0] {
    SC_NORMAL = 3'd0,
    SC_SLASH  = 3'd1,
    SC_BLOCK  = 3'd2,
    SC_BSTAR  = 3'd3,
    SC_LINE   = 3'd4
  } scan_state_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic [31:0] count;
    logic        last;
  } line_beat_t;

  localparam int PHASE_ITEMS = 450;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;    // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;            // [7:0] out_byte, [39:8] line_count
  logic [1:0]  m_tuser;            // [1:0] kind
  logic        m_tlast;

  logic [7:0]  text_bytes[$];
  line_beat_t  want_beats[$];
  line_beat_t  staged[$];
  scan_state_t scan_state = SC_NORMAL;
  logic [31:0] lines_seen = '0;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          hold_src = 1'b0;
  int          errors = 0;
  int          queued = 0;

  comment_stripping_line_splitter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic bit is_eot(logic [7:0] b);
    return b == CH_NUL || b == CH_FF;
  endfunction

  function automatic void stage_beat(logic [7:0] data, kind_t kind);
    line_beat_t t;
    t.data  = data;
    t.kind  = kind;
    t.count = lines_seen;
    t.last  = 1'b0;
    staged.push_back(t);
  endfunction

  function automatic void end_line(kind_t kind);
    lines_seen = lines_seen + 32'd1;
    scan_state = SC_NORMAL;
    stage_beat(8'h00, kind);
  endfunction

  function automatic void scan_text(logic [7:0] b);
    if (is_eot(b)) begin
      end_line(KIND_EOT);
    end else if (b == CH_LF) begin
      end_line(KIND_EOL);
    end else if (b == CH_SLASH) begin
      scan_state = SC_SLASH;
    end else if (b != CH_CR) begin
      scan_state = SC_NORMAL;
      stage_beat(b, KIND_TEXT);
    end
  endfunction

  // Advance the scanner by one byte and queue the beats it yields.
  function automatic void predict_beats(logic [7:0] b);
    staged.delete();
    case (scan_state)
      SC_SLASH: begin
        if (b == CH_STAR) begin
          scan_state = SC_BLOCK;
        end else if (b == CH_SLASH) begin
          scan_state = SC_LINE;
        end else begin
          scan_state = SC_NORMAL;
          stage_beat(CH_SLASH, KIND_TEXT);
          scan_text(b);
        end
      end
      SC_BLOCK: begin
        if (is_eot(b)) end_line(KIND_EOT);
        else if (b == CH_STAR) scan_state = SC_BSTAR;
      end
      SC_BSTAR: begin
        if (is_eot(b)) end_line(KIND_EOT);
        else if (b == CH_SLASH) scan_state = SC_NORMAL;
        else if (b != CH_STAR) scan_state = SC_BLOCK;
      end
      SC_LINE: begin
        if (is_eot(b)) end_line(KIND_EOT);
        else if (b == CH_LF) end_line(KIND_EOL);
      end
      default: begin
        scan_state = SC_NORMAL;
        scan_text(b);
      end
    endcase
    if (staged.size() > 0) begin
      staged[staged.size() - 1].last = 1'b1;
      foreach (staged[i]) want_beats.push_back(staged[i]);
    end
  endfunction

  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready === 1'b1) predict_beats(s_tdata);
      if (!s_tvalid || s_tready === 1'b1) begin
        if (text_bytes.size() > 0 && !hold_src && $urandom_range(99) >= src_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= text_bytes.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    line_beat_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid === 1'b1 && m_tready) begin
        if (want_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat data %h kind %0d count %0d",
                                    m_tdata[7:0], m_tuser, m_tdata[39:8]));
        end else begin
          w = want_beats.pop_front();
          check_field("out_byte", 32'(m_tdata[7:0]), 32'(w.data));
          check_field("kind", 32'(m_tuser), 32'(w.kind));
          check_field("line_count", m_tdata[39:8], w.count);
          check_field("last", 32'(m_tlast), 32'(w.last));
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic push_byte(logic [7:0] b);
    text_bytes.push_back(b);
    queued++;
  endtask

  // Mostly well-formed text: plain bytes, line ends, lone slashes and both comment
  // styles, with some end-of-text marks and raw noise mixed in.
  task automatic add_token();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 40) begin
      push_byte(8'($urandom_range(1, 254)));
    end else if (r < 50) begin
      push_byte($urandom_range(1) ? CH_LF : CH_CR);
    end else if (r < 60) begin
      push_byte(CH_SLASH);
      push_byte(8'($urandom_range(0, 255)));
    end else if (r < 70) begin
      push_byte(CH_SLASH);
      push_byte(CH_SLASH);
      n = $urandom_range(0, 6);
      repeat (n) push_byte(8'($urandom_range(1, 254)));
      push_byte($urandom_range(7) == 0 ? CH_FF : CH_LF);
    end else if (r < 84) begin
      push_byte(CH_SLASH);
      push_byte(CH_STAR);
      n = $urandom_range(0, 6);
      repeat (n) push_byte($urandom_range(3) == 0 ? CH_STAR : 8'($urandom_range(1, 254)));
      if ($urandom_range(9) == 0) begin
        push_byte($urandom_range(1) ? CH_NUL : CH_FF);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) push_byte(CH_STAR);
        push_byte(CH_SLASH);
      end
    end else if (r < 90) begin
      push_byte($urandom_range(1) ? CH_NUL : CH_FF);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (text_bytes.size() > 0 || s_tvalid || want_beats.size() > 0) @(negedge clk);
  endtask

  task automatic run_phase(int src_pct, int snk_pct, bit pause_src);
    src_idle = src_pct;
    snk_idle = snk_pct;
    queued = 0;
    while (queued < PHASE_ITEMS) add_token();
    if (pause_src) begin
      while (text_bytes.size() > PHASE_ITEMS / 2) @(negedge clk);
      // Hold new bytes until the block has delivered everything in flight.
      hold_src = 1'b1;
      while (s_tvalid || want_beats.size() > 0) @(negedge clk);
      repeat (3) @(negedge clk);
      hold_src = 1'b0;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    logic [7:0] directed[] = '{
      8'h01, 8'hFE, CH_CR, CH_LF,
      CH_SLASH, "x",
      CH_SLASH, CH_NUL,
      CH_SLASH, CH_SLASH, "c", CH_LF,
      CH_SLASH, CH_STAR, CH_LF, CH_STAR, CH_STAR, CH_SLASH, "z",
      CH_SLASH, CH_STAR, CH_STAR, CH_FF,
      CH_SLASH, CH_SLASH, CH_FF
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    src_idle = 37;
    snk_idle = 63;
    foreach (directed[i]) push_byte(directed[i]);
    wait_drained();
    run_phase(37, 63, 1'b1);
    run_phase(63, 37, 1'b0);
    run_phase(0, 0, 1'b0);
    repeat (10) @(negedge clk);
    if (want_beats.size() > 0)
      report_mismatch($sformatf("%0d expected beats never arrived", want_beats.size()));
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: comment_stripping_line_splitter.f
+incdir+sv
sv/ccs_pkg.sv
sv/ccs_front.sv
sv/ccs_fifo.sv
sv/ccs_back.sv
sv/comment_stripping_line_splitter.sv
tb/sv/comment_stripping_line_splitter_tb.sv
